[rtl/core/obb_sat_pkg.sv]
// Package for the OBB/OBB separating axis test: formats, widths, payload types.
// Used by every file in rtl/core; depends on nothing.
package obb_sat_pkg;

  localparam int COMPONENT_WIDTH = 16;
  localparam int C         = COMPONENT_WIDTH;
  localparam int WORD_W    = 48;
  localparam int AXIS_FRAC = C - 2;

  localparam int D_W   = C + 1;       // centre difference
  localparam int PA_W  = 2 * C;       // axis x axis product
  localparam int PD_W  = 2 * C + 1;   // difference x axis product
  localparam int T_W   = 2 * C + 3;   // projected centre distance
  localparam int M_W   = 2 * C + 2;   // rotation matrix entry
  localparam int EM_W  = C + M_W;     // extent x |m|
  localparam int TM_W  = T_W + M_W;   // t x m
  localparam int CMP_W = 5 * C + 4;   // comparison width, signed

  localparam int NUM_AXES = 15;
  localparam int AXIS_W   = 4;
  localparam logic [AXIS_W-1:0] NO_SEP = AXIS_W'(15);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_A_CENTER     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_A_AXIS_U     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_A_AXIS_V     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_A_AXIS_W     = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_A_HALF_SIZES = CFG_IDX_W'(4);

  typedef logic [WORD_W-1:0]        word_t;
  typedef logic signed [T_W-1:0]    t_t;
  typedef logic signed [M_W-1:0]    m_t;
  typedef logic [C-1:0]             ext_t;
  typedef logic signed [CMP_W-1:0]  cmp_t;

  typedef struct packed {
    word_t box_b_center;
    word_t box_b_axis_u;
    word_t box_b_axis_v;
    word_t box_b_axis_w;
    word_t box_b_half_sizes;
  } in_t;

  typedef struct packed {
    logic              overlap;
    logic [AXIS_W-1:0] separating_axis;
  } out_t;

  typedef struct packed {
    word_t box_a_center;
    word_t box_a_axis_u;
    word_t box_a_axis_v;
    word_t box_a_axis_w;
    word_t box_a_half_sizes;
  } cfg_t;

  // component k of a packed word; bits beyond the word read as zero
  function automatic logic [C-1:0] get_comp(input word_t w, input int k);
    logic [3*C+WORD_W-1:0] x;
    x = (3*C+WORD_W)'(w);
    return x[k*C +: C];
  endfunction

endpackage

[rtl/core/obb_sat_proj.sv]
// Stages A and B: centre difference, projections t and rotation matrix m.
// Depends on obb_sat_pkg.
module obb_sat_proj
  import obb_sat_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  in_t  in_i,
  input  cfg_t cfg_i,
  output logic vld_o,
  output t_t   t_o [3],
  output m_t   m_o [3][3],
  output ext_t eb_o [3]
);

  logic signed [C-1:0]    a_ax [3][3];
  logic signed [C-1:0]    b_ax [3][3];
  logic signed [D_W-1:0]  d    [3];
  ext_t                   eb   [3];

  logic                   vld_a_q, vld_b_q;
  logic signed [PA_W-1:0] pab_q [3][3][3];
  logic signed [PD_W-1:0] pda_q [3][3];
  ext_t                   eb_a_q [3], eb_b_q [3];
  t_t                     t_q [3];
  m_t                     m_q [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      a_ax[0][k] = $signed(get_comp(cfg_i.box_a_axis_u, k));
      a_ax[1][k] = $signed(get_comp(cfg_i.box_a_axis_v, k));
      a_ax[2][k] = $signed(get_comp(cfg_i.box_a_axis_w, k));
      b_ax[0][k] = $signed(get_comp(in_i.box_b_axis_u, k));
      b_ax[1][k] = $signed(get_comp(in_i.box_b_axis_v, k));
      b_ax[2][k] = $signed(get_comp(in_i.box_b_axis_w, k));
      d[k] = D_W'($signed(get_comp(in_i.box_b_center, k)))
           - D_W'($signed(get_comp(cfg_i.box_a_center, k)));
      eb[k] = get_comp(in_i.box_b_half_sizes, k);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
      vld_b_q <= 1'b0;
    end else if (en_i) begin
      vld_a_q <= vld_i;
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        eb_a_q[i] <= eb[i];
        eb_b_q[i] <= eb_a_q[i];
        for (int k = 0; k < 3; k++) begin
          pda_q[i][k] <= d[k] * a_ax[i][k];
        end
        for (int j = 0; j < 3; j++) begin
          for (int k = 0; k < 3; k++) begin
            pab_q[i][j][k] <= a_ax[i][k] * b_ax[j][k];
          end
          m_q[i][j] <= M_W'(pab_q[i][j][0]) + M_W'(pab_q[i][j][1]) + M_W'(pab_q[i][j][2]);
        end
        t_q[i] <= T_W'(pda_q[i][0]) + T_W'(pda_q[i][1]) + T_W'(pda_q[i][2]);
      end
    end
  end

  assign vld_o = vld_b_q;
  assign t_o   = t_q;
  assign m_o   = m_q;
  assign eb_o  = eb_b_q;

endmodule

[rtl/core/obb_sat_radius.sv]
// Stages C and D: projected radii and distances for all 15 axes.
// Depends on obb_sat_pkg.
module obb_sat_radius
  import obb_sat_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  t_t    t_i [3],
  input  m_t    m_i [3][3],
  input  ext_t  eb_i [3],
  input  word_t ea_word_i,
  output logic  vld_o,
  output cmp_t  lhs_o [NUM_AXES],
  output cmp_t  rhs_o [NUM_AXES]
);

  ext_t                   ea [3];
  logic [M_W-1:0]         m_abs [3][3];

  logic                   vld_c_q, vld_d_q;
  logic signed [TM_W-1:0] tm_q  [3][3][3];
  logic [EM_W-1:0]        ema_q [3][3][3];
  logic [EM_W-1:0]        emb_q [3][3][3];
  logic [T_W-1:0]         tabs_q [3];
  ext_t                   eb_c_q [3];
  cmp_t                   lhs_d [NUM_AXES], rhs_d [NUM_AXES];
  cmp_t                   lhs_q [NUM_AXES], rhs_q [NUM_AXES];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ea[i] = get_comp(ea_word_i, i);
      for (int j = 0; j < 3; j++) begin
        m_abs[i][j] = m_i[i][j][M_W-1] ? M_W'(-m_i[i][j]) : M_W'(m_i[i][j]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
      vld_d_q <= 1'b0;
    end else if (en_i) begin
      vld_c_q <= vld_i;
      vld_d_q <= vld_c_q;
    end
  end

  // stage C: all products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int x = 0; x < 3; x++) begin
        eb_c_q[x] <= eb_i[x];
        tabs_q[x] <= t_i[x][T_W-1] ? T_W'(-t_i[x]) : T_W'(t_i[x]);
        for (int y = 0; y < 3; y++) begin
          for (int z = 0; z < 3; z++) begin
            tm_q[x][y][z]  <= TM_W'(t_i[x]) * TM_W'(m_i[y][z]);
            ema_q[x][y][z] <= EM_W'(ea[x]) * EM_W'(m_abs[y][z]);
            emb_q[x][y][z] <= EM_W'(eb_i[x]) * EM_W'(m_abs[y][z]);
          end
        end
      end
    end
  end

  // stage D: sums per axis, all at scale 3 * AXIS_FRAC
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cmp_t r, s, a;
      // A's axes: emb index is [b extent][row][col]
      lhs_d[i] = cmp_t'(tabs_q[i]) <<< (2 * AXIS_FRAC);
      r = cmp_t'(emb_q[0][i][0]) + cmp_t'(emb_q[1][i][1]) + cmp_t'(emb_q[2][i][2]);
      rhs_d[i] = (cmp_t'(ea[i]) <<< (3 * AXIS_FRAC)) + (r <<< AXIS_FRAC);
      // B's axes
      s = cmp_t'(tm_q[0][0][i]) + cmp_t'(tm_q[1][1][i]) + cmp_t'(tm_q[2][2][i]);
      lhs_d[3 + i] = s[CMP_W-1] ? -s : s;
      a = cmp_t'(ema_q[0][0][i]) + cmp_t'(ema_q[1][1][i]) + cmp_t'(ema_q[2][2][i]);
      rhs_d[3 + i] = (a <<< AXIS_FRAC) + (cmp_t'(eb_c_q[i]) <<< (3 * AXIS_FRAC));
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        int   i1, i2, j1, j2;
        cmp_t s, r;
        i1 = (i + 1) % 3;
        i2 = (i + 2) % 3;
        j1 = (j + 1) % 3;
        j2 = (j + 2) % 3;
        s = cmp_t'(tm_q[i2][i1][j]) - cmp_t'(tm_q[i1][i2][j]);
        r = cmp_t'(ema_q[i1][i2][j]) + cmp_t'(ema_q[i2][i1][j])
          + cmp_t'(emb_q[j1][i][j2]) + cmp_t'(emb_q[j2][i][j1]);
        lhs_d[6 + 3 * i + j] = s[CMP_W-1] ? -s : s;
        rhs_d[6 + 3 * i + j] = r <<< AXIS_FRAC;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lhs_q <= lhs_d;
      rhs_q <= rhs_d;
    end
  end

  assign vld_o = vld_d_q;
  assign lhs_o = lhs_q;
  assign rhs_o = rhs_q;

endmodule

[rtl/core/obb_sat_decide.sv]
// Stage E: strict compare per axis, first-axis priority pick, output register.
// Depends on obb_sat_pkg.
module obb_sat_decide
  import obb_sat_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic vld_i,
  input  cmp_t lhs_i [NUM_AXES],
  input  cmp_t rhs_i [NUM_AXES],
  output logic vld_o,
  output out_t out_o
);

  logic [AXIS_W-1:0] axis;
  logic              out_vld_q;
  out_t              out_d, out_q;

  always_comb begin
    axis = NO_SEP;
    for (int a = NUM_AXES - 1; a >= 0; a--) begin
      if (lhs_i[a] > rhs_i[a]) begin
        axis = AXIS_W'(a);
      end
    end
    out_d.overlap         = (axis == NO_SEP);
    out_d.separating_axis = axis;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en_i) begin
      out_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= out_d;
    end
  end

  assign vld_o = out_vld_q;
  assign out_o = out_q;

endmodule

[rtl/core/obb_obb_separating_axis_test.sv]
// Top level of the OBB/OBB 15-axis separating axis test.
// Depends on obb_sat_pkg, obb_sat_proj, obb_sat_radius, obb_sat_decide.
//
//  channel  | handshake                      | payload
//  ---------+--------------------------------+-----------------------------
//  in       | in_valid_i / in_stall_o        | in_data_i  (in_t, box B)
//  out      | out_valid_o / out_stall_i      | out_data_o (out_t)
//  cfg      | cfg_valid_i / cfg_ready_o      | cfg_index_i, cfg_data_i
//
// One transaction per cycle when not stalled: A products, B sums (t, m),
//   C radius/distance products, D per-axis sums, E compare and output reg.
// The five stages advance together; a stall on the output side holds them
//   all, and in_stall_o follows only while the output register is full.
// Reset zeroes the valid bits and box A registers. Box A is read live;
// the user must rewrite it only with no transaction in flight (unenforced).
module obb_obb_separating_axis_test
  import obb_sat_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_t                 out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  word_t                cfg_data_i
);

  cfg_t cfg_q;
  logic en;
  logic vld_b, vld_d;
  t_t   t    [3];
  m_t   m    [3][3];
  ext_t eb   [3];
  cmp_t lhs  [NUM_AXES];
  cmp_t rhs  [NUM_AXES];

  // whole pipe moves unless the output holds a transaction that is stalled
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_A_CENTER:     cfg_q.box_a_center     <= cfg_data_i;
        REG_A_AXIS_U:     cfg_q.box_a_axis_u     <= cfg_data_i;
        REG_A_AXIS_V:     cfg_q.box_a_axis_v     <= cfg_data_i;
        REG_A_AXIS_W:     cfg_q.box_a_axis_w     <= cfg_data_i;
        REG_A_HALF_SIZES: cfg_q.box_a_half_sizes <= cfg_data_i;
        default: ;        // out-of-range index: ignored
      endcase
    end
  end

  obb_sat_proj u_proj (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_valid_i),
    .in_i   (in_data_i),
    .cfg_i  (cfg_q),
    .vld_o  (vld_b),
    .t_o    (t),
    .m_o    (m),
    .eb_o   (eb)
  );

  obb_sat_radius u_radius (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .vld_i     (vld_b),
    .t_i       (t),
    .m_i       (m),
    .eb_i      (eb),
    .ea_word_i (cfg_q.box_a_half_sizes),
    .vld_o     (vld_d),
    .lhs_o     (lhs),
    .rhs_o     (rhs)
  );

  obb_sat_decide u_decide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_d),
    .lhs_i  (lhs),
    .rhs_i  (rhs),
    .vld_o  (out_valid_o),
    .out_o  (out_data_o)
  );

endmodule

[tb/sv/obb_obb_separating_axis_test_test.sv]
// Testbench for obb_obb_separating_axis_test: directed and random box B queries against a
// configurable box A, checked against an in-bench 15-axis separating axis predictor.
// Depends on obb_sat_pkg and the RTL top level only.
`timescale 1ns / 100ps

module obb_obb_separating_axis_test_test;
  import obb_sat_pkg::*;

  localparam int Q_FRAC = COMPONENT_WIDTH - 2;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_t                  in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_t                 out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  word_t                cfg_data;

  obb_obb_separating_axis_test DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Clock: 10 ns period
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Box A as the predictor sees it
  cfg_t box_a;

  in_t  box_b_queue[$];   // box B transactions waiting to be offered
  out_t verdict_queue[$]; // predicted verdicts, oldest first
  int   failures;
  int   sender_idle_pct;
  int   receiver_idle_pct;
  int   hold_cycles;      // long receiver hold-off, counted down by the receiver
  logic offer_held;       // offer was stalled at the last rising edge

  // Signed component k of a word; bits past the word read as zero
  function automatic longint comp_s(word_t w, int k);
    logic [3*COMPONENT_WIDTH+WORD_W-1:0] x;
    logic [COMPONENT_WIDTH-1:0]          c;
    x = {{(3*COMPONENT_WIDTH){1'b0}}, w};
    c = x[k*COMPONENT_WIDTH +: COMPONENT_WIDTH];
    return longint'($signed(c));
  endfunction

  function automatic longint comp_u(word_t w, int k);
    logic [3*COMPONENT_WIDTH+WORD_W-1:0] x;
    x = {{(3*COMPONENT_WIDTH){1'b0}}, w};
    return longint'({1'b0, x[k*COMPONENT_WIDTH +: COMPONENT_WIDTH]});
  endfunction

  function automatic logic signed [159:0] wide(longint v);
    return 160'(signed'(v));
  endfunction

  function automatic logic signed [159:0] wabs(logic signed [159:0] v);
    return v < 0 ? -v : v;
  endfunction

  // Separating axis verdict for box B against the current box A
  function automatic out_t sat_verdict(in_t b);
    longint aax[3][3], bax[3][3], ea[3], eb[3], d[3], m[3][3], t[3];
    logic signed [159:0] proj_dist, rsum, s;
    int axis, i1, i2, j1, j2;
    word_t aw[3], bw[3];
    out_t v;
    aw[0] = box_a.box_a_axis_u; aw[1] = box_a.box_a_axis_v; aw[2] = box_a.box_a_axis_w;
    bw[0] = b.box_b_axis_u;     bw[1] = b.box_b_axis_v;     bw[2] = b.box_b_axis_w;
    axis = NUM_AXES;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        aax[i][k] = comp_s(aw[i], k);
        bax[i][k] = comp_s(bw[i], k);
      end
      ea[i] = comp_u(box_a.box_a_half_sizes, i);
      eb[i] = comp_u(b.box_b_half_sizes, i);
      d[i]  = comp_s(b.box_b_center, i) - comp_s(box_a.box_a_center, i);
    end
    for (int i = 0; i < 3; i++) begin
      t[i] = 0;
      for (int k = 0; k < 3; k++) t[i] += d[k] * aax[i][k];
      for (int j = 0; j < 3; j++) begin
        m[i][j] = 0;
        for (int k = 0; k < 3; k++) m[i][j] += aax[i][k] * bax[j][k];
      end
    end
    // A's face axes, compared at scale 3*Q_FRAC
    for (int i = 0; i < 3; i++) begin
      if (axis == NUM_AXES) begin
        proj_dist = wabs(wide(t[i])) <<< (2 * Q_FRAC);
        rsum = 0;
        for (int j = 0; j < 3; j++) rsum += wide(eb[j]) * wabs(wide(m[i][j]));
        rsum = (wide(ea[i]) <<< (3 * Q_FRAC)) + (rsum <<< Q_FRAC);
        if (proj_dist > rsum) axis = i;
      end
    end
    // B's face axes
    for (int j = 0; j < 3; j++) begin
      if (axis == NUM_AXES) begin
        s = 0;
        rsum = 0;
        for (int i = 0; i < 3; i++) begin
          s += wide(t[i]) * wide(m[i][j]);
          rsum += wide(ea[i]) * wabs(wide(m[i][j]));
        end
        rsum = (rsum <<< Q_FRAC) + (wide(eb[j]) <<< (3 * Q_FRAC));
        if (wabs(s) > rsum) axis = 3 + j;
      end
    end
    // Edge cross products A_i x B_j
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (axis == NUM_AXES) begin
          i1 = (i + 1) % 3; i2 = (i + 2) % 3;
          j1 = (j + 1) % 3; j2 = (j + 2) % 3;
          rsum = wide(ea[i1]) * wabs(wide(m[i2][j])) + wide(ea[i2]) * wabs(wide(m[i1][j]))
               + wide(eb[j1]) * wabs(wide(m[i][j2])) + wide(eb[j2]) * wabs(wide(m[i][j1]));
          s = wide(t[i2]) * wide(m[i1][j]) - wide(t[i1]) * wide(m[i2][j]);
          if (wabs(s) > (rsum <<< Q_FRAC)) axis = 6 + 3 * i + j;
        end
      end
    end
    v.overlap         = (axis == NUM_AXES);
    v.separating_axis = AXIS_W'(axis);
    return v;
  endfunction

  function automatic word_t pack3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic word_t rand_word();
    return {16'($urandom_range(0, 16'hFFFF)), $urandom()};
  endfunction

  // Unit-ish axis: one dominant component of either sign plus small noise
  function automatic word_t rand_axis();
    int c[3];
    int k;
    k = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) c[i] = $signed($urandom_range(0, 2048)) - 1024;
    c[k] = $urandom_range(0, 1) ? 16384 : -16384;
    return pack3(c[0], c[1], c[2]);
  endfunction

  function automatic word_t rand_centre();
    return pack3($urandom_range(0, 4096) - 2048, $urandom_range(0, 4096) - 2048,
                 $urandom_range(0, 4096) - 2048);
  endfunction

  function automatic word_t rand_ext();
    return pack3($urandom_range(0, 1024), $urandom_range(0, 1024), $urandom_range(0, 1024));
  endfunction

  // Mostly plausible boxes near A, some raw noise across the whole word
  function automatic in_t rand_box();
    in_t b;
    if ($urandom_range(0, 9) < 8) begin
      b.box_b_center     = rand_centre();
      b.box_b_axis_u     = rand_axis();
      b.box_b_axis_v     = rand_axis();
      b.box_b_axis_w     = rand_axis();
      b.box_b_half_sizes = rand_ext();
    end else begin
      b = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
    end
    return b;
  endfunction

  // Driver: offers box B transactions at the falling edge. The predictor runs at
  // acceptance so it sees box A as it stands for that transaction.
  always @(posedge clk) begin
    offer_held <= rst_n && in_valid && in_stall;
    if (rst_n && in_valid && !in_stall) begin
      verdict_queue.push_back(sat_verdict(in_data));
      void'(box_b_queue.pop_front());
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (offer_held) begin
      in_valid <= 1'b1; // stalled payload holds
    end else if (box_b_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
      in_valid <= 1'b1;
      in_data  <= box_b_queue[0];
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Monitor: compares each accepted verdict against the oldest prediction
  always @(posedge clk) begin
    out_t exp_v;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_queue.size() == 0) begin
        $display("%0t: unexpected verdict %b/%0d", $time,
                 out_data.overlap, out_data.separating_axis);
        failures++;
      end else begin
        exp_v = verdict_queue.pop_front();
        if (out_data.overlap !== exp_v.overlap) begin
          $display("%0t: overlap mismatch, expected %b actual %b", $time,
                   exp_v.overlap, out_data.overlap);
          failures++;
        end
        if (out_data.separating_axis !== exp_v.separating_axis) begin
          $display("%0t: separating_axis mismatch, expected %0d actual %0d", $time,
                   exp_v.separating_axis, out_data.separating_axis);
          failures++;
        end
      end
    end
  end

  // Receiver stall, with a long hold-off when requested
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_A_CENTER)     box_a.box_a_center     = val;
    if (idx == REG_A_AXIS_U)     box_a.box_a_axis_u     = val;
    if (idx == REG_A_AXIS_V)     box_a.box_a_axis_v     = val;
    if (idx == REG_A_AXIS_W)     box_a.box_a_axis_w     = val;
    if (idx == REG_A_HALF_SIZES) box_a.box_a_half_sizes = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_box_a(word_t c, word_t u, word_t v, word_t w, word_t e);
    write_reg(REG_A_CENTER, c);
    write_reg(REG_A_AXIS_U, u);
    write_reg(REG_A_AXIS_V, v);
    write_reg(REG_A_AXIS_W, w);
    write_reg(REG_A_HALF_SIZES, e);
  endtask

  // Waits until every transaction is out, plus pipeline settle time
  task automatic drain();
    wait (box_b_queue.size() == 0 && verdict_queue.size() == 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic queue_box(word_t c, word_t u, word_t v, word_t w, word_t e);
    in_t b;
    b = {c, u, v, w, e};
    box_b_queue.push_back(b);
  endtask

  task automatic random_phase(int n, int s_pct, int r_pct);
    sender_idle_pct   = s_pct;
    receiver_idle_pct = r_pct;
    for (int i = 0; i < n; i++) box_b_queue.push_back(rand_box());
    drain();
  endtask

  initial begin
    word_t ex, ey, ez, one;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    box_a       = '0;
    failures    = 0;
    hold_cycles = 0;
    offer_held  = 1'b0;
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    ex  = pack3(16384, 0, 0);
    ey  = pack3(0, 16384, 0);
    ez  = pack3(0, 0, 16384);
    one = pack3(256, 256, 256);

    // Reset box A (all zero): degenerate axes against two boxes
    queue_box('0, '0, '0, '0, '0);
    queue_box('1, '1, '1, '1, '1);
    drain();

    // Axis-aligned unit boxes: overlap, touching, and separation on each face
    load_box_a('0, ex, ey, ez, one);
    queue_box('0, ex, ey, ez, one);                     // coincident
    queue_box(pack3(512, 0, 0), ex, ey, ez, one);       // touching: no separation
    queue_box(pack3(513, 0, 0), ex, ey, ez, one);       // A's u separates
    queue_box(pack3(0, -513, 0), ex, ey, ez, one);      // A's v
    queue_box(pack3(0, 0, 513), ex, ey, ez, one);       // A's w
    queue_box(pack3(0, 0, 600), ez, ey, ex, one);       // swapped axes
    queue_box(pack3(-32768, 32767, -32768), ex, ey, ez, pack3(65535, 65535, 65535));
    queue_box(pack3(32767, -32768, 32767), pack3(-32768, -32768, -32768),
              pack3(32767, 32767, 32767), '1, '0);      // extreme components
    queue_box(pack3(300, 300, 0), pack3(11585, 11585, 0), pack3(-11585, 11585, 0), ez,
              pack3(128, 128, 128));                    // rotated 45 degrees
    drain();

    // Degenerate A axes so B's face axes and the cross products decide
    load_box_a('0, ex, '0, '0, '0);
    queue_box(pack3(0, 400, 0), ey, ex, ez, pack3(64, 64, 64));
    queue_box(pack3(0, 0, 400), ez, ey, ex, pack3(64, 64, 64));
    queue_box(pack3(0, 300, 300), pack3(11585, 11585, 0), ez, ey, pack3(32, 32, 32));
    queue_box(pack3(0, 300, 300), ey, ez, ex, '0);
    drain();

    // Random phases: sender 37 / receiver 50, then swapped for the next two phases
    load_box_a(rand_centre(), rand_axis(), rand_axis(), rand_axis(), rand_ext());
    random_phase(230, 37, 50);
    load_box_a(rand_word(), rand_word(), rand_word(), rand_word(), rand_word());
    random_phase(60, 50, 37);
    load_box_a(rand_centre(), ex, ey, ez, pack3(1024, 1024, 1024));
    random_phase(180, 50, 37);
    // Index beyond the register file must be ignored
    write_reg(CFG_IDX_W'(7), '1);
    write_reg(CFG_IDX_W'(5), '1);
    load_box_a(rand_centre(), rand_axis(), rand_axis(), rand_axis(), '1);
    // Long receiver hold-off while the sender keeps offering, to back up the pipe
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    hold_cycles       = 60;
    random_phase(230, 0, 0);

    drain();
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
